### design/lact_pkg.sv
// Shared types and constants for the LRU age cache tracker.
`default_nettype none

package lact_pkg;

    localparam int ADDR_W  = 22;
    localparam int AGE_W   = 5;
    localparam int SHIFT_W = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_SIZE_LOG2 = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SET_COUNT_LOG2 = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WAYS           = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MUST_MODE      = 2'd3;

    // Configuration reset values.
    localparam logic [SHIFT_W-1:0] RST_LINE_SIZE_LOG2 = 4'd6;
    localparam logic [SHIFT_W-1:0] RST_SET_COUNT_LOG2 = 4'd6;
    localparam logic [AGE_W-1:0]   RST_WAYS           = 5'd4;

    // One stored entry: the touched flag beside the line's age.
    typedef struct packed {
        logic             touched;
        logic [AGE_W-1:0] age;
    } t_age_word;

    typedef struct packed {
        logic             hit;
        logic [AGE_W-1:0] old_age;
        logic             first_touch;
        logic             out_of_range;
    } t_result;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ISSUE,
        ST_LOOKUP,
        ST_SWEEP
    } t_state;

endpackage

`default_nettype wire

### design/lact_age_ram.sv
// Age and touched-flag memory with one write port and one registered read port.
`default_nettype none

module lact_age_ram
    import lact_pkg::*;
#(
    parameter int DEPTH = 1024,
    parameter int IDX_W = 10
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [IDX_W-1:0] i_waddr,
    input  wire t_age_word        i_wdata,
    input  wire logic             i_re,
    input  wire logic [IDX_W-1:0] i_raddr,
    output t_age_word             o_rdata
);

    t_age_word r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

### design/lru_age_cache_tracker_top.sv
// Top level of the LRU age cache tracker: control sequencer, configuration and result slot.
// Usage
// Each request on the input channel carries one byte address. The line index is the
// address shifted down by line_size_log2; its set is that index modulo 2^set_count_log2.
// For every request exactly one result leaves on the output channel, in order.
// A request is taken when i_in_valid is high and o_in_stall is low; a result is taken
// when o_out_valid is high and i_out_stall is low.
// Sequence: an in-range request reads its own line, then the first line of its set, then
// sweeps the N tracked lines of the set, ceil((TRACKED_LINES - set) / 2^set_count_log2):
// 16 lines with the default geometry. The sweep is set by the single age memory, which it
// reads and writes back one line per cycle. An out-of-range request leaves the memory alone.
// The result enters a pending slot in the LOOKUP state (ISSUE for an out-of-range request) and
// sits there until the output register is free, so it may wait while its sweep runs.
// Reset (synchronous, active low) restores the configuration registers and then runs a
// clearing pass that writes every line back to its reset age and untouched; o_in_stall
// stays high meanwhile. Configuration writes are always accepted.
// A stalled receiver holds the output register steady; once the pending slot is also full
// the block stops taking requests.
`default_nettype none

module lru_age_cache_tracker_top
    import lact_pkg::*;
#(
    parameter int TRACKED_LINES = 1024,
    parameter int MAX_WAYS      = 16
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // Request channel.
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire logic [ADDR_W-1:0]     i_byte_address,
    // Result channel.
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output logic                       o_hit,
    output logic [AGE_W-1:0]           o_old_age,
    output logic                       o_first_touch,
    output logic                       o_out_of_range,
    // Configuration write channel.
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int IDX_W = $clog2(TRACKED_LINES);
    localparam int STP_W = IDX_W + 1;
    localparam logic [ADDR_W-1:0] LINES_A = ADDR_W'(TRACKED_LINES);
    localparam logic [STP_W-1:0]  LINES_S = STP_W'(TRACKED_LINES);
    localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(TRACKED_LINES - 1);
    // The age every line holds after reset is the effective ways at reset.
    localparam logic [AGE_W-1:0]  RESET_AGE =
        (MAX_WAYS < int'(RST_WAYS)) ? AGE_W'(MAX_WAYS) : RST_WAYS;

    // Configuration registers.
    logic [SHIFT_W-1:0] r_line_size_log2;
    logic [SHIFT_W-1:0] r_set_count_log2;
    logic [AGE_W-1:0]   r_ways;
    logic               r_must_mode;

    // Sequencer state.
    t_state             r_state;
    t_state             n_state;
    logic [IDX_W-1:0]   r_clr;
    logic [IDX_W-1:0]   r_idx;

    // Per-request context, captured on acceptance.
    logic               r_oor;
    logic [IDX_W-1:0]   r_line_idx;
    logic [IDX_W-1:0]   r_set;
    logic [STP_W-1:0]   r_step;
    logic [AGE_W-1:0]   r_old;

    // Pending result and output register.
    logic               r_pend_valid;
    t_result            r_pend;
    logic               r_out_valid;
    t_result            r_out;

    // Memory port signals.
    logic               w_we;
    logic [IDX_W-1:0]   w_waddr;
    t_age_word          w_wdata;
    logic               w_re;
    logic [IDX_W-1:0]   w_raddr;
    t_age_word          w_rdata;

    logic               w_in_acc;
    logic [ADDR_W-1:0]  w_line;
    logic [STP_W-1:0]   w_step;
    logic [STP_W-1:0]   w_step_m1;
    logic [STP_W-1:0]   w_next_idx;
    logic               w_last;
    logic [AGE_W-1:0]   w_eff_ways;
    t_age_word          w_upd;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_size_log2 <= RST_LINE_SIZE_LOG2;
            r_set_count_log2 <= RST_SET_COUNT_LOG2;
            r_ways           <= RST_WAYS;
            r_must_mode      <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_LINE_SIZE_LOG2: r_line_size_log2 <= i_cfg_data[SHIFT_W-1:0];
                CFG_SET_COUNT_LOG2: r_set_count_log2 <= i_cfg_data[SHIFT_W-1:0];
                CFG_WAYS:           r_ways           <= i_cfg_data[AGE_W-1:0];
                CFG_MUST_MODE:      r_must_mode      <= i_cfg_data[0];
            endcase
        end
    end

    // Ways beyond what the block tracks saturate at MAX_WAYS.
    assign w_eff_ways = (int'(r_ways) > MAX_WAYS) ? AGE_W'(MAX_WAYS) : r_ways;

    // Line index and set stride of the incoming request. A stride that reaches past the
    // tracked range is clamped, so every set then holds at most one tracked line.
    assign w_in_acc = i_in_valid && !o_in_stall;
    assign w_line   = i_byte_address >> r_line_size_log2;

    always_comb begin
        if (int'(r_set_count_log2) >= IDX_W) begin
            w_step = {1'b1, {IDX_W{1'b0}}};
        end else begin
            w_step = STP_W'(1) << r_set_count_log2;
        end
    end

    assign w_step_m1 = w_step - STP_W'(1);

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_oor      <= (w_line >= LINES_A);
            r_line_idx <= w_line[IDX_W-1:0];
            r_set      <= w_line[IDX_W-1:0] & w_step_m1[IDX_W-1:0];
            r_step     <= w_step;
        end
    end

    // Sweep bookkeeping: r_idx is the line whose data arrives from memory this cycle.
    assign w_next_idx = {1'b0, r_idx} + r_step;
    assign w_last     = (w_next_idx >= LINES_S);

    // Ageing rule for one line of the set.
    always_comb begin
        w_upd = w_rdata;
        if (r_idx == r_line_idx) begin
            w_upd.touched = 1'b1;
            w_upd.age     = '0;
        end else if ((w_rdata.age < r_old || (w_rdata.age == r_old && !r_must_mode))
                     && w_rdata.age < w_eff_ways) begin
            w_upd.age = w_rdata.age + AGE_W'(1);
        end
    end

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR:  if (r_clr == LAST_IDX) n_state = ST_IDLE;
            ST_IDLE:   if (w_in_acc) n_state = ST_ISSUE;
            ST_ISSUE:  n_state = r_oor ? ST_IDLE : ST_LOOKUP;
            ST_LOOKUP: n_state = ST_SWEEP;
            ST_SWEEP:  if (w_last) n_state = ST_IDLE;
        endcase
    end

    // Memory control and request stall by state.
    always_comb begin
        w_we       = 1'b0;
        w_waddr    = r_idx;
        w_wdata    = w_upd;
        w_re       = 1'b0;
        w_raddr    = r_idx;
        o_in_stall = 1'b1;
        unique case (r_state)
            ST_CLEAR: begin
                w_we          = 1'b1;
                w_waddr       = r_clr;
                w_wdata.touched = 1'b0;
                w_wdata.age   = RESET_AGE;
            end
            ST_IDLE: begin
                o_in_stall = r_pend_valid;
            end
            ST_ISSUE: begin
                w_re    = !r_oor;
                w_raddr = r_line_idx;
            end
            ST_LOOKUP: begin
                w_re    = 1'b1;
                w_raddr = r_set;
            end
            ST_SWEEP: begin
                w_we    = 1'b1;
                w_re    = !w_last;
                w_raddr = w_next_idx[IDX_W-1:0];
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_clr   <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) begin
                r_clr <= r_clr + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_LOOKUP) begin
            r_old <= w_rdata.age;
            r_idx <= r_set;
        end else if (r_state == ST_SWEEP) begin
            r_idx <= w_next_idx[IDX_W-1:0];
        end
    end

    // The pending slot fills once the old age is known, or once a request is found out of range,
    // and drains into the output register whenever that is empty or being taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (r_state == ST_LOOKUP || (r_state == ST_ISSUE && r_oor)) begin
                r_pend_valid <= 1'b1;
            end else if (r_pend_valid && (!r_out_valid || !i_out_stall)) begin
                r_pend_valid <= 1'b0;
            end
            if (r_pend_valid && (!r_out_valid || !i_out_stall)) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_LOOKUP) begin
            r_pend.hit          <= (w_rdata.age < w_eff_ways);
            r_pend.old_age      <= w_rdata.age;
            r_pend.first_touch  <= !w_rdata.touched;
            r_pend.out_of_range <= 1'b0;
        end else if (r_state == ST_ISSUE && r_oor) begin
            r_pend.hit          <= 1'b0;
            r_pend.old_age      <= '0;
            r_pend.first_touch  <= 1'b0;
            r_pend.out_of_range <= 1'b1;
        end
        if (r_pend_valid && (!r_out_valid || !i_out_stall)) begin
            r_out <= r_pend;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_hit          = r_out.hit;
    assign o_old_age      = r_out.old_age;
    assign o_first_touch  = r_out.first_touch;
    assign o_out_of_range = r_out.out_of_range;

    lact_age_ram #(
        .DEPTH (TRACKED_LINES),
        .IDX_W (IDX_W)
    ) u_age_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

endmodule

`default_nettype wire

### design/lact_checker.sv
// Port-level checks for the LRU age cache tracker, bound to its top level.
`default_nettype none

module lact_checker
    import lact_pkg::*;
(
    input wire logic                  i_clk,
    input wire logic                  i_rst_n,
    input wire logic                  i_in_valid,
    input wire logic                  o_in_stall,
    input wire logic                  o_out_valid,
    input wire logic                  i_out_stall,
    input wire logic                  o_hit,
    input wire logic [AGE_W-1:0]      o_old_age,
    input wire logic                  o_first_touch,
    input wire logic                  o_out_of_range
);

    // No result is offered straight after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result offered after reset");

    // An out-of-range result carries no hit, age or first touch.
    a_oor_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_of_range |-> !o_hit && o_old_age == '0 && !o_first_touch)
        else $error("out-of-range result with payload");

    // The largest age can never be below the effective ways, so it is never a hit.
    a_max_age_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_old_age == '1 |-> !o_hit)
        else $error("hit reported at maximum age");

    // Requests are handled one at a time: the port stalls right after taking one.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("second request taken while the first is in progress");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_old_age) && $stable(o_hit))
        else $error("stalled result changed");

endmodule

bind lru_age_cache_tracker_top lact_checker u_lact_checker (.*);

`default_nettype wire
